FILE: rtl/core/ism_pkg.sv
// ----------------------------------------------------------------------------
// ism_pkg
// Shared codes and field widths for the interval set block.
// ----------------------------------------------------------------------------
package ism_pkg;

  // field widths of the input and result words
  localparam int ACTION_W = 2;
  localparam int STATUS_W = 2;
  localparam int INDEX_W  = 4;
  localparam int COUNT_W  = 5;
  localparam int FIELD_W  = 32;

  typedef logic [ACTION_W-1:0] action_t;
  typedef logic [STATUS_W-1:0] status_t;

  // action codes
  localparam action_t ACT_ADD    = 2'd0;
  localparam action_t ACT_REMOVE = 2'd1;
  localparam action_t ACT_READ   = 2'd2;

  // status codes
  localparam status_t STAT_OK    = 2'd0;
  localparam status_t STAT_FULL  = 2'd1;
  localparam status_t STAT_RANGE = 2'd2;

endpackage

FILE: rtl/core/interval_set_merge_split.sv
// ----------------------------------------------------------------------------
// interval_set_merge_split
// Sorted table of disjoint inclusive ranges with add (merge), remove (split)
// and indexed read, held in a ping-pong memory.
// ----------------------------------------------------------------------------
// Usage: an input word (action, range bounds, entry index) is taken on the
// in_ channel, one result word (status, entry count, entry bounds) leaves on
// the out_ channel for every input word. Swapped bounds are put in order.
// The table lives in one memory split into two banks. An add or remove reads
// every stored entry of the live bank once and writes the new table into
// the other bank; the banks swap only if the new table fits, otherwise
// status is full and nothing changes. An entry that writes two words (an
// insertion point, a split) takes an extra step to write the second word.
// One word is in work at a time; in_ready is high only when the block is
// free.
// The result sits in an output register; while the receiver stalls, the
// block finishes the next word and then holds it until the register frees.
// Reset (rst_n low, synchronous) empties the table and drops any result.
// ----------------------------------------------------------------------------
module interval_set_merge_split #(
  parameter int MAX_RANGES = 16,
  parameter int VALUE_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [ism_pkg::ACTION_W-1:0]      in_action,
  input  logic [ism_pkg::FIELD_W-1:0]       in_range_low,
  input  logic [ism_pkg::FIELD_W-1:0]       in_range_high,
  input  logic [ism_pkg::INDEX_W-1:0]       in_entry_index,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [ism_pkg::STATUS_W-1:0]      out_status,
  output logic [ism_pkg::COUNT_W-1:0]       out_entry_count,
  output logic [ism_pkg::FIELD_W-1:0]       out_entry_low,
  output logic [ism_pkg::FIELD_W-1:0]       out_entry_high
);

  localparam int VB    = VALUE_BITS;
  localparam int IDX_W = $clog2(MAX_RANGES);
  localparam int CNT_W = $clog2(MAX_RANGES + 1);
  localparam int WC_W  = $clog2(MAX_RANGES + 2);
  localparam int WF_W  = WC_W + 1;
  localparam int AW    = IDX_W + 1;
  localparam int DEPTH = 2 ** AW;
  localparam logic [WC_W-1:0] WI_SAT   = WC_W'(MAX_RANGES + 1);
  localparam logic [WF_W-1:0] FULL_LIM = WF_W'(MAX_RANGES);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_PR   = 3'd2;
  localparam logic [2:0] S_PR2  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  // table memory, two banks
  logic [VB-1:0] mem_lo [DEPTH];
  logic [VB-1:0] mem_hi [DEPTH];

  logic [2:0]                   state_r, state_nxt;
  ism_pkg::action_t             op_r, op_nxt;
  logic [VB-1:0]                lo_r, lo_nxt, hi_r, hi_nxt;
  logic [VB-1:0]                qlo_r, qlo_nxt, qhi_r, qhi_nxt;
  logic [ism_pkg::INDEX_W-1:0]  idx_r, idx_nxt;
  logic [CNT_W-1:0]             cnt_r, cnt_nxt, ri_r, ri_nxt;
  logic [WC_W-1:0]              wi_r, wi_nxt;
  logic                         bank_r, bank_nxt, placed_r, placed_nxt;
  ism_pkg::status_t             stat_r, stat_nxt;
  logic                         rd_ok_r, rd_ok_nxt;
  logic                         out_valid_r, out_valid_nxt;
  ism_pkg::status_t             out_status_r, out_status_nxt;
  logic [ism_pkg::COUNT_W-1:0]  out_cnt_r, out_cnt_nxt;
  logic [ism_pkg::FIELD_W-1:0]  out_lo_r, out_lo_nxt, out_hi_r, out_hi_nxt;

  logic [VB-1:0]  rd_lo_r, rd_hi_r;
  logic           rd_en;
  logic [AW-1:0]  rd_addr, wr_addr;
  logic           we;
  logic [VB-1:0]  wr_lo, wr_hi;

  // input bounds cut to the value width and put in order
  logic [VB+ism_pkg::FIELD_W-1:0] lo_ext, hi_ext;
  logic [VB-1:0]                  in_lo_v, in_hi_v;
  assign lo_ext  = {{VB{1'b0}}, in_range_low};
  assign hi_ext  = {{VB{1'b0}}, in_range_high};
  assign in_lo_v = lo_ext[VB-1:0];
  assign in_hi_v = hi_ext[VB-1:0];

  // compares against the stored word, one bit wider so end + 1 never wraps
  logic [VB:0] el1, eh1, lo1, hi1;
  logic        below, above, meets, covered;
  assign el1     = {1'b0, rd_lo_r};
  assign eh1     = {1'b0, rd_hi_r};
  assign lo1     = {1'b0, lo_r};
  assign hi1     = {1'b0, hi_r};
  assign below   = (eh1 + 1'b1) < lo1;
  assign above   = el1 > (hi1 + 1'b1);
  assign meets   = (rd_hi_r >= lo_r) && (rd_lo_r <= hi_r);
  assign covered = (lo_r <= rd_lo_r) && (rd_hi_r <= hi_r);

  // read index checks and misc widening
  logic [CNT_W+ism_pkg::INDEX_W-1:0] idx_c, cnt_c;
  logic [IDX_W+ism_pkg::INDEX_W-1:0] idx_w;
  logic [CNT_W+ism_pkg::COUNT_W-1:0] cnt_rep;
  logic [VB+ism_pkg::FIELD_W-1:0]    rlo_ext, rhi_ext;
  logic                              idx_ok;
  logic [CNT_W-1:0]                  ri_inc;
  logic [WF_W-1:0]                   fin_cnt;
  logic                              add_pend;
  assign idx_c    = {{CNT_W{1'b0}}, in_entry_index};
  assign cnt_c    = {{ism_pkg::INDEX_W{1'b0}}, cnt_r};
  assign idx_ok   = idx_c < cnt_c;
  assign idx_w    = {{IDX_W{1'b0}}, idx_r};
  assign cnt_rep  = {{ism_pkg::COUNT_W{1'b0}}, cnt_r};
  assign rlo_ext  = {{ism_pkg::FIELD_W{1'b0}}, rd_lo_r};
  assign rhi_ext  = {{ism_pkg::FIELD_W{1'b0}}, rd_hi_r};
  assign ri_inc   = ri_r + 1'b1;
  assign add_pend = (op_r == ism_pkg::ACT_ADD) && !placed_r;
  assign fin_cnt  = {1'b0, wi_r} + WF_W'(add_pend);

  assign in_ready = (state_r == S_IDLE);
  assign wr_addr  = {~bank_r, wi_r[IDX_W-1:0]};

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    qlo_nxt        = qlo_r;
    qhi_nxt        = qhi_r;
    idx_nxt        = idx_r;
    cnt_nxt        = cnt_r;
    ri_nxt         = ri_r;
    wi_nxt         = wi_r;
    bank_nxt       = bank_r;
    placed_nxt     = placed_r;
    stat_nxt       = stat_r;
    rd_ok_nxt      = rd_ok_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_cnt_nxt    = out_cnt_r;
    out_lo_nxt     = out_lo_r;
    out_hi_nxt     = out_hi_r;
    rd_en          = 1'b0;
    rd_addr        = {bank_r, ri_r[IDX_W-1:0]};
    we             = 1'b0;
    wr_lo          = rd_lo_r;
    wr_hi          = rd_hi_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt     = in_action;
          idx_nxt    = in_entry_index;
          lo_nxt     = (in_lo_v > in_hi_v) ? in_hi_v : in_lo_v;
          hi_nxt     = (in_lo_v > in_hi_v) ? in_lo_v : in_hi_v;
          ri_nxt     = '0;
          wi_nxt     = '0;
          placed_nxt = 1'b0;
          stat_nxt   = ism_pkg::STAT_OK;
          rd_ok_nxt  = 1'b0;
          if (in_action == ism_pkg::ACT_READ) begin
            if (idx_ok) begin
              rd_ok_nxt = 1'b1;
              state_nxt = S_RD;
            end else begin
              stat_nxt  = ism_pkg::STAT_RANGE;
              state_nxt = S_OUT;
            end
          end else if (in_action == ism_pkg::ACT_ADD ||
                       in_action == ism_pkg::ACT_REMOVE) begin
            state_nxt = (cnt_r == '0) ? S_FIN : S_RD;
          end else begin
            state_nxt = S_OUT;
          end
        end
      end
      S_RD: begin
        rd_en = 1'b1;
        if (op_r == ism_pkg::ACT_READ) begin
          rd_addr   = {bank_r, idx_w[IDX_W-1:0]};
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_PR;
        end
      end
      S_PR: begin
        state_nxt = (ri_inc == cnt_r) ? S_FIN : S_RD;
        ri_nxt    = ri_inc;
        if (op_r == ism_pkg::ACT_ADD) begin
          if (placed_r || below) begin
            we = 1'b1;
          end else if (above) begin
            // new range goes in front of this entry
            we         = 1'b1;
            wr_lo      = lo_r;
            wr_hi      = hi_r;
            placed_nxt = 1'b1;
            qlo_nxt    = rd_lo_r;
            qhi_nxt    = rd_hi_r;
            state_nxt  = S_PR2;
            ri_nxt     = ri_r;
          end else begin
            // overlapping or touching entry folds into the range
            if (rd_lo_r < lo_r) lo_nxt = rd_lo_r;
            if (rd_hi_r > hi_r) hi_nxt = rd_hi_r;
          end
        end else begin
          if (!meets) begin
            we = 1'b1;
          end else if (rd_lo_r == rd_hi_r || covered) begin
            we = 1'b0;
          end else if (rd_lo_r < lo_r) begin
            // left leftover, right leftover follows if the entry splits
            we    = 1'b1;
            wr_lo = rd_lo_r;
            wr_hi = lo_r - 1'b1;
            if (rd_hi_r > hi_r) begin
              qlo_nxt   = hi_r + 1'b1;
              qhi_nxt   = rd_hi_r;
              state_nxt = S_PR2;
              ri_nxt    = ri_r;
            end
          end else begin
            we    = 1'b1;
            wr_lo = hi_r + 1'b1;
            wr_hi = rd_hi_r;
          end
        end
      end
      S_PR2: begin
        we        = 1'b1;
        wr_lo     = qlo_r;
        wr_hi     = qhi_r;
        ri_nxt    = ri_inc;
        state_nxt = (ri_inc == cnt_r) ? S_FIN : S_RD;
      end
      S_FIN: begin
        if (add_pend) begin
          we    = 1'b1;
          wr_lo = lo_r;
          wr_hi = hi_r;
        end
        if (fin_cnt > FULL_LIM) begin
          stat_nxt = ism_pkg::STAT_FULL;
        end else begin
          bank_nxt = ~bank_r;
          cnt_nxt  = fin_cnt[CNT_W-1:0];
        end
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = stat_r;
          out_cnt_nxt    = cnt_rep[ism_pkg::COUNT_W-1:0];
          out_lo_nxt     = rd_ok_r ? rlo_ext[ism_pkg::FIELD_W-1:0] : '0;
          out_hi_nxt     = rd_ok_r ? rhi_ext[ism_pkg::FIELD_W-1:0] : '0;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    // write count saturates one past the table size
    if (we && wi_r != WI_SAT) wi_nxt = wi_r + 1'b1;
  end

  // table memory ports, writes past the table size are dropped
  always_ff @(posedge clk) begin
    if (we && ({1'b0, wi_r} < FULL_LIM)) begin
      mem_lo[wr_addr] <= wr_lo;
      mem_hi[wr_addr] <= wr_hi;
    end
    if (rd_en) begin
      rd_lo_r <= mem_lo[rd_addr];
      rd_hi_r <= mem_hi[rd_addr];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      bank_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      bank_r      <= bank_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working and result registers
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    qlo_r        <= qlo_nxt;
    qhi_r        <= qhi_nxt;
    idx_r        <= idx_nxt;
    ri_r         <= ri_nxt;
    wi_r         <= wi_nxt;
    placed_r     <= placed_nxt;
    stat_r       <= stat_nxt;
    rd_ok_r      <= rd_ok_nxt;
    out_status_r <= out_status_nxt;
    out_cnt_r    <= out_cnt_nxt;
    out_lo_r     <= out_lo_nxt;
    out_hi_r     <= out_hi_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_entry_count = out_cnt_r;
  assign out_entry_low   = out_lo_r;
  assign out_entry_high  = out_hi_r;

  // checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, cnt_r} <= {1'b0, FULL_LIM[CNT_W-1:0]})
    else $error("stored count above table size");

  a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second word taken while busy");

  a_second_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PR2) |-> ($past(state_r) == S_PR))
    else $error("second write without a processed entry");

  a_swap_on_fit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && fin_cnt > FULL_LIM) |=> $stable(bank_r))
    else $error("bank swapped on a full table");

endmodule

FILE: tb/sv/tb_interval_set_merge_split.sv
// ----------------------------------------------------------------------------
// tb_interval_set_merge_split
// Drives add, remove, read and unused-action words into the interval set block
// with random gaps on both sides, predicts every result word from a behavioral
// copy of the range table, and compares each result field by field.
// ----------------------------------------------------------------------------
module tb_interval_set_merge_split;

  localparam int MAX_RANGES = 16;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct packed {
    ism_pkg::action_t                   action;
    logic [ism_pkg::FIELD_W-1:0]        lo;
    logic [ism_pkg::FIELD_W-1:0]        hi;
    logic [ism_pkg::INDEX_W-1:0]        idx;
  } cmd_word_t;

  typedef struct packed {
    ism_pkg::status_t                   status;
    logic [ism_pkg::COUNT_W-1:0]        count;
    logic [ism_pkg::FIELD_W-1:0]        lo;
    logic [ism_pkg::FIELD_W-1:0]        hi;
  } res_word_t;

  localparam ism_pkg::action_t ACT_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [ism_pkg::ACTION_W-1:0] in_action = '0;
  logic [ism_pkg::FIELD_W-1:0] in_range_low = '0;
  logic [ism_pkg::FIELD_W-1:0] in_range_high = '0;
  logic [ism_pkg::INDEX_W-1:0] in_entry_index = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [ism_pkg::STATUS_W-1:0] out_status;
  logic [ism_pkg::COUNT_W-1:0] out_entry_count;
  logic [ism_pkg::FIELD_W-1:0] out_entry_low;
  logic [ism_pkg::FIELD_W-1:0] out_entry_high;

  interval_set_merge_split #(.MAX_RANGES(MAX_RANGES), .VALUE_BITS(ism_pkg::FIELD_W)) u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_action(in_action),
    .in_range_low(in_range_low), .in_range_high(in_range_high),
    .in_entry_index(in_entry_index),
    .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
    .out_entry_count(out_entry_count), .out_entry_low(out_entry_low),
    .out_entry_high(out_entry_high)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  cmd_word_t pending_words[$];
  res_word_t expected_results[$];
  bit stim_done = 1'b0;
  int errors = 0;
  int cycle_count = 0;
  int hold_off = 0;

  // predictor copy of the table, 64-bit so that +1 cannot wrap
  longint unsigned tbl_lo[MAX_RANGES];
  longint unsigned tbl_hi[MAX_RANGES];
  int tbl_count = 0;

  function automatic bit joins(longint unsigned al, longint unsigned ah,
                               longint unsigned bl, longint unsigned bh);
    return (ah >= bl && al <= bh) || (ah + 1 == bl) || (bh + 1 == al);
  endfunction

  function automatic ism_pkg::status_t commit_table(longint unsigned nl[$],
                                                    longint unsigned nh[$]);
    if (nl.size() > MAX_RANGES) return ism_pkg::STAT_FULL;
    foreach (nl[i]) begin
      tbl_lo[i] = nl[i];
      tbl_hi[i] = nh[i];
    end
    tbl_count = nl.size();
    return ism_pkg::STAT_OK;
  endfunction

  function automatic res_word_t apply_word(cmd_word_t w);
    res_word_t r;
    longint unsigned lo, hi, el, eh;
    longint unsigned nl[$], nh[$];
    bit covered, placed;
    r = '0;
    lo = (w.lo > w.hi) ? 64'(w.hi) : 64'(w.lo);
    hi = (w.lo > w.hi) ? 64'(w.lo) : 64'(w.hi);
    r.status = ism_pkg::STAT_OK;
    case (w.action)
      ism_pkg::ACT_ADD: begin
        covered = 1'b0;
        for (int i = 0; i < tbl_count; i++)
          if (tbl_lo[i] <= lo && hi <= tbl_hi[i]) covered = 1'b1;
        if (!covered) begin
          for (int i = 0; i < tbl_count; i++)
            if (joins(tbl_lo[i], tbl_hi[i], lo, hi)) begin
              if (tbl_lo[i] < lo) lo = tbl_lo[i];
              if (tbl_hi[i] > hi) hi = tbl_hi[i];
            end
          placed = 1'b0;
          for (int i = 0; i < tbl_count; i++) begin
            el = tbl_lo[i];
            eh = tbl_hi[i];
            if (joins(el, eh, lo, hi)) continue;
            if (!placed && el > hi) begin
              nl.push_back(lo);
              nh.push_back(hi);
              placed = 1'b1;
            end
            nl.push_back(el);
            nh.push_back(eh);
          end
          if (!placed) begin
            nl.push_back(lo);
            nh.push_back(hi);
          end
          r.status = commit_table(nl, nh);
        end
      end
      ism_pkg::ACT_REMOVE: begin
        if (tbl_count != 0) begin
          for (int i = 0; i < tbl_count; i++) begin
            el = tbl_lo[i];
            eh = tbl_hi[i];
            if (!(eh >= lo && el <= hi)) begin
              nl.push_back(el);
              nh.push_back(eh);
              continue;
            end
            if (el == eh || (lo <= el && eh <= hi)) continue;
            if (el < lo) begin
              nl.push_back(el);
              nh.push_back(lo - 1);
            end
            if (eh > hi) begin
              nl.push_back(hi + 1);
              nh.push_back(eh);
            end
          end
          r.status = commit_table(nl, nh);
        end
      end
      ism_pkg::ACT_READ: begin
        if (w.idx < tbl_count) begin
          r.lo = tbl_lo[w.idx][ism_pkg::FIELD_W-1:0];
          r.hi = tbl_hi[w.idx][ism_pkg::FIELD_W-1:0];
        end else begin
          r.status = ism_pkg::STAT_RANGE;
        end
      end
      default: ;
    endcase
    r.count = tbl_count[ism_pkg::COUNT_W-1:0];
    return r;
  endfunction

  function automatic cmd_word_t mk(ism_pkg::action_t a, logic [31:0] l, logic [31:0] h,
                                   logic [3:0] x);
    cmd_word_t w;
    w.action = a;
    w.lo = l;
    w.hi = h;
    w.idx = x;
    return w;
  endfunction

  function automatic logic [31:0] rand_value(int unsigned window);
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return 32'hFFFF_FFFF - $urandom_range(0, 40);
      default: return $urandom_range(0, window);
    endcase
  endfunction

  // stimulus: directed cases, then random words
  initial begin
    int unsigned window;
    logic [31:0] a;
    pending_words.push_back(mk(ism_pkg::ACT_READ, 0, 0, 0));
    pending_words.push_back(mk(ism_pkg::ACT_REMOVE, 5, 9, 0));
    pending_words.push_back(mk(ism_pkg::ACT_ADD, 20, 10, 0));
    pending_words.push_back(mk(ism_pkg::ACT_ADD, 12, 15, 0));
    pending_words.push_back(mk(ism_pkg::ACT_ADD, 21, 30, 0));
    pending_words.push_back(mk(ism_pkg::ACT_ADD, 0, 8, 0));
    pending_words.push_back(mk(ism_pkg::ACT_ADD, 9, 9, 0));
    pending_words.push_back(mk(ism_pkg::ACT_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFF0, 0));
    pending_words.push_back(mk(ism_pkg::ACT_ADD, 0, 0, 0));
    pending_words.push_back(mk(ism_pkg::ACT_READ, 0, 0, 0));
    pending_words.push_back(mk(ism_pkg::ACT_READ, 0, 0, 1));
    pending_words.push_back(mk(ism_pkg::ACT_READ, 0, 0, 15));
    pending_words.push_back(mk(ism_pkg::ACT_REMOVE, 12, 14, 0));
    pending_words.push_back(mk(ism_pkg::ACT_REMOVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0));
    pending_words.push_back(mk(ism_pkg::ACT_REMOVE, 5, 5, 0));
    pending_words.push_back(mk(ACT_UNUSED, 32'hFFFF_FFFF, 32'h5555_AAAA, 4'hF));
    pending_words.push_back(mk(ism_pkg::ACT_READ, 0, 0, 2));
    for (int i = 0; i < 17; i++)
      pending_words.push_back(mk(ism_pkg::ACT_ADD, 100 + 4 * i, 100 + 4 * i, 0));
    pending_words.push_back(mk(ism_pkg::ACT_REMOVE, 0, 32'hFFFF_FFFF, 0));
    for (int k = 0; k < 1100; k++) begin
      window = (k % 200 < 100) ? 200 : 5000;
      a = rand_value(window);
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7:
          pending_words.push_back(mk(ism_pkg::ACT_ADD, a, a + $urandom_range(0, 12), 0));
        8, 9, 10, 11, 12:
          pending_words.push_back(mk(ism_pkg::ACT_REMOVE, a, a + $urandom_range(0, 6), 0));
        13:
          pending_words.push_back(mk(ism_pkg::ACT_REMOVE, rand_value(window),
                                     rand_value(window), 0));
        14, 15, 16, 17:
          pending_words.push_back(mk(ism_pkg::ACT_READ, $urandom, $urandom,
                                     4'($urandom_range(0, 15))));
        18:
          pending_words.push_back(mk(ism_pkg::ACT_ADD, $urandom, $urandom, 4'($urandom)));
        default:
          pending_words.push_back(mk(ACT_UNUSED, $urandom, $urandom, 4'($urandom)));
      endcase
    end
    stim_done = 1'b1;
  end

  // reset
  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
  end

  // driver: presents the next word, random gaps between words
  int send_gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_results.push_back(apply_word({in_action, in_range_low, in_range_high,
                                               in_entry_index}));
        send_gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) send_gap = 0;
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          cmd_word_t w;
          w = pending_words.pop_front();
          in_valid <= 1'b1;
          in_action <= w.action;
          in_range_low <= w.lo;
          in_range_high <= w.hi;
          in_entry_index <= w.idx;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stalls, one long hold-off early in the random part
  bit did_hold = 1'b0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off--;
      out_ready <= 1'b0;
    end else if (!did_hold && pending_words.size() < 900 && pending_words.size() > 0) begin
      did_hold = 1'b1;
      hold_off = 400;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 29) == 0) begin
      hold_off = $urandom_range(10, 60);
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 3) != 0) || (cycle_count % 1000 < 200);
    end
  end

  // monitor: compare each result word with the oldest expectation
  always @(posedge clk) begin
    res_word_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result status=%0d count=%0d", $time, out_status,
                 out_entry_count);
        errors++;
      end else begin
        exp_r = expected_results.pop_front();
        if (out_status !== exp_r.status) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_r.status, out_status);
          errors++;
        end
        if (out_entry_count !== exp_r.count) begin
          $display("%0t: count expected %0d actual %0d", $time, exp_r.count,
                   out_entry_count);
          errors++;
        end
        if (out_entry_low !== exp_r.lo) begin
          $display("%0t: entry low expected %h actual %h", $time, exp_r.lo, out_entry_low);
          errors++;
        end
        if (out_entry_high !== exp_r.hi) begin
          $display("%0t: entry high expected %h actual %h", $time, exp_r.hi,
                   out_entry_high);
          errors++;
        end
      end
    end
  end

  // end of run and timeout
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    wait (stim_done);
    while (pending_words.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (60) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/ism_pkg.sv
rtl/core/interval_set_merge_split.sv
tb/sv/tb_interval_set_merge_split.sv
